>>> src/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared constants, codes and types of the block allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned NUM_BLOCKS = 4096;
  localparam int unsigned MAX_RUN    = 64;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NUM_WORDS  = NUM_BLOCKS / WORD_W;
  localparam int unsigned WADDR_W    = 6;
  localparam int unsigned BLK_W      = 12;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned POS_W      = 6;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLAIM = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_FREE = 2'd2;

  localparam logic REG_FIRST_DATA = 1'b0;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } find_t;

endpackage

>>> src/bitmap_run_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run block allocator
// Next-fit allocator over a free bitmap held in a 64 x 64-bit memory.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every bitmap word with busy high.
// An item is taken when start is high and busy is low; its single result
// appears on block_number_o/status_o for one cycle with done_o and must be
// taken then. Free reads the bitmap word and writes it back, and also the next
// word unless the run starts in the last word; claim reads one word and writes
// it back if the block is free; no-op and allocate with an empty count answer
// straight from idle. Allocate reads one bitmap word per cycle from the memory port, in at most two passes.
// ----------------------------------------------------------------------------
module bitmap_run_block_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode_i,
  input  logic [bra_pkg::BLK_W-1:0]   start_block_i,
  input  logic [bra_pkg::LEN_W-1:0]   run_length_i,
  output logic                        done_o,
  output logic [bra_pkg::BLK_W-1:0]   block_number_o,
  output logic [1:0]                  status_o
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_A_SETUP = 4'd2;
  localparam logic [3:0] S_A_SCAN  = 4'd3;
  localparam logic [3:0] S_A_WR0   = 4'd4;
  localparam logic [3:0] S_A_WR1   = 4'd5;
  localparam logic [3:0] S_F_RD    = 4'd6;
  localparam logic [3:0] S_F_WR0   = 4'd7;
  localparam logic [3:0] S_F_WR1   = 4'd8;
  localparam logic [3:0] S_C_RD    = 4'd9;
  localparam logic [3:0] S_C_WR    = 4'd10;

  localparam int unsigned W  = bra_pkg::WORD_W;
  localparam int unsigned AW = bra_pkg::WADDR_W;
  localparam int unsigned BW = bra_pkg::BLK_W;
  localparam int unsigned CW = bra_pkg::CNT_W;
  localparam int unsigned LW = bra_pkg::LEN_W;
  localparam logic [CW-1:0] NUM_BLK = CW'(bra_pkg::NUM_BLOCKS);
  localparam logic [LW-1:0] MAX_LEN = LW'(bra_pkg::MAX_RUN);
  localparam logic [AW-1:0] LAST_W  = AW'(bra_pkg::NUM_WORDS - 1);
  localparam logic REG_FIRST_DATA_BIT = bra_pkg::REG_FIRST_DATA;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_k_q, clr_k_d;
  logic [BW-1:0] blk_q, blk_d;
  logic [LW-1:0] len_q, len_d;
  logic [BW-1:0] fdb_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] count_q, count_d;
  logic [BW-1:0] rotor_q, rotor_d;
  logic          retry_q, retry_d;
  logic [AW:0]   issue_k_q, issue_k_d;
  logic          pend_q, pend_d;
  logic [AW:0]   pend_k_q, pend_k_d;
  logic [W-1:0]  prev_raw_q, prev_raw_d;
  logic [W-1:0]  prev_m_q, prev_m_d;
  logic [W-1:0]  wr_cur_q, wr_cur_d;
  logic [W-1:0]  wr_prev_q, wr_prev_d;
  logic [AW-1:0] wr_k_q, wr_k_d;
  logic          span_q, span_d;
  logic [BW-1:0] s_q, s_d;
  logic          done_q, done_d;
  logic [BW-1:0] bn_q, bn_d;
  logic [1:0]    st_q, st_d;

  logic [W-1:0]  mem [bra_pkg::NUM_WORDS];
  logic [W-1:0]  rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [W-1:0]  mem_wdata;

  logic [CW-1:0]   limit, limit_m1, lo;
  logic [AW:0]     lo_word, end_word;
  logic [W-1:0]    low_m, high_m, cur_m;
  logic [LW-1:0]   len_sat;
  bra_pkg::find_t  find;
  logic [W-1:0]    run_mask;
  logic [2*W-1:0]  alloc_mask, free_mask;
  logic [7:0]      sh;
  logic [CW:0]     sum;
  logic [CW-1:0]   s_full;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_FIRST_DATA_BIT) ? {20'd0, fdb_q} : {19'd0, total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q   <= BW'(1);
      total_q <= NUM_BLK;
    end else if (cfg_we) begin
      if (paddr[2] == REG_FIRST_DATA_BIT) begin
        fdb_q <= pwdata[BW-1:0];
      end else begin
        total_q <= pwdata[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign limit    = (total_q < NUM_BLK) ? total_q : NUM_BLK;
  assign limit_m1 = limit - CW'(1);
  assign lo       = {1'b0, rotor_q} + CW'(1);
  assign lo_word  = lo[CW-1:AW];
  assign end_word = limit_m1[CW-1:AW];
  assign len_sat  = (run_length_i > MAX_LEN) ? MAX_LEN : run_length_i;

  assign low_m  = (pend_k_q == lo_word) ? ({W{1'b1}} << lo[AW-1:0]) : {W{1'b1}};
  assign high_m = (pend_k_q == end_word) ?
                  ({W{1'b1}} >> (AW'(W - 1) - limit_m1[AW-1:0])) : {W{1'b1}};
  assign cur_m  = rdata_q & low_m & high_m;

  bra_run_find u_find (
    .window_i ({cur_m, prev_m_q}),
    .len_i    (len_q),
    .find_o   (find)
  );

  assign run_mask   = {W{1'b1}} >> (MAX_LEN - len_q);
  assign sh         = 8'(find.pos) + 8'd65 - 8'(len_q);
  assign alloc_mask = {{W{1'b0}}, run_mask} << sh[6:0];
  assign free_mask  = {{W{1'b0}}, run_mask} << blk_q[AW-1:0];
  assign s_full     = {pend_k_q, {AW{1'b0}}} + CW'(find.pos) + CW'(1) - CW'(len_q);
  assign sum        = {1'b0, count_q} + (CW+1)'(len_q);

  always_comb begin
    state_d    = state_q;
    clr_k_d    = clr_k_q;
    blk_d      = blk_q;
    len_d      = len_q;
    count_d    = count_q;
    rotor_d    = rotor_q;
    retry_d    = retry_q;
    issue_k_d  = issue_k_q;
    pend_d     = pend_q;
    pend_k_d   = pend_k_q;
    prev_raw_d = prev_raw_q;
    prev_m_d   = prev_m_q;
    wr_cur_d   = wr_cur_q;
    wr_prev_d  = wr_prev_q;
    wr_k_d     = wr_k_q;
    span_d     = span_q;
    s_d        = s_q;
    done_d     = 1'b0;
    bn_d       = bn_q;
    st_d       = st_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;

    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_k_q;
        clr_k_d   = clr_k_q + AW'(1);
        if (clr_k_q == LAST_W) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          blk_d = start_block_i;
          len_d = len_sat;
          unique case (opcode_i)
            bra_pkg::OP_ALLOC: begin
              len_d = (len_sat == '0) ? LW'(1) : len_sat;
              if (count_q == '0) begin
                done_d = 1'b1;
                bn_d   = '0;
                st_d   = bra_pkg::ST_NO_SPACE;
              end else begin
                if (!(fdb_q <= rotor_q && {1'b0, rotor_q} < limit)) begin
                  rotor_d = fdb_q;
                end
                retry_d = 1'b0;
                state_d = S_A_SETUP;
              end
            end
            bra_pkg::OP_FREE:  state_d = S_F_RD;
            bra_pkg::OP_CLAIM: state_d = S_C_RD;
            default: begin
              done_d = 1'b1;
              bn_d   = '0;
              st_d   = bra_pkg::ST_OK;
            end
          endcase
        end
      end
      S_A_SETUP: begin
        prev_raw_d = '0;
        prev_m_d   = '0;
        pend_d     = 1'b0;
        issue_k_d  = lo_word;
        if (lo >= limit) begin
          if (!retry_q && rotor_q > fdb_q) begin
            rotor_d = fdb_q;
            retry_d = 1'b1;
          end else begin
            done_d  = 1'b1;
            bn_d    = '0;
            st_d    = bra_pkg::ST_NO_SPACE;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        pend_k_d = issue_k_q;
        if (issue_k_q <= end_word) begin
          mem_re    = 1'b1;
          mem_raddr = issue_k_q[AW-1:0];
          issue_k_d = issue_k_q + (AW+1)'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (find.hit) begin
            wr_cur_d  = rdata_q & ~alloc_mask[2*W-1:W];
            wr_prev_d = prev_raw_q & ~alloc_mask[W-1:0];
            span_d    = |alloc_mask[W-1:0];
            wr_k_d    = pend_k_q[AW-1:0];
            s_d       = s_full[BW-1:0];
            state_d   = S_A_WR0;
          end else begin
            prev_raw_d = rdata_q;
            prev_m_d   = cur_m;
            if (pend_k_q == end_word) begin
              if (!retry_q && rotor_q > fdb_q) begin
                rotor_d = fdb_q;
                retry_d = 1'b1;
                state_d = S_A_SETUP;
              end else begin
                done_d  = 1'b1;
                bn_d    = '0;
                st_d    = bra_pkg::ST_NO_SPACE;
                state_d = S_IDLE;
              end
            end
          end
        end
      end
      S_A_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = wr_k_q;
        mem_wdata = wr_cur_q;
        if (span_q) begin
          state_d = S_A_WR1;
        end else begin
          count_d = (count_q > CW'(len_q)) ? count_q - CW'(len_q) : '0;
          rotor_d = s_q;
          done_d  = 1'b1;
          bn_d    = s_q;
          st_d    = bra_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      S_A_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = wr_k_q - AW'(1);
        mem_wdata = wr_prev_q;
        count_d   = (count_q > CW'(len_q)) ? count_q - CW'(len_q) : '0;
        rotor_d   = s_q;
        done_d    = 1'b1;
        bn_d      = s_q;
        st_d      = bra_pkg::ST_OK;
        state_d   = S_IDLE;
      end
      S_F_RD: begin
        mem_re    = 1'b1;
        mem_raddr = blk_q[BW-1:AW];
        state_d   = S_F_WR0;
      end
      S_F_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = blk_q[BW-1:AW];
        mem_wdata = rdata_q | free_mask[W-1:0];
        if (blk_q[BW-1:AW] != LAST_W) begin
          mem_re    = 1'b1;
          mem_raddr = blk_q[BW-1:AW] + AW'(1);
          state_d   = S_F_WR1;
        end else begin
          count_d = (sum > (CW+1)'(NUM_BLK)) ? NUM_BLK : sum[CW-1:0];
          done_d  = 1'b1;
          bn_d    = '0;
          st_d    = bra_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      S_F_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = blk_q[BW-1:AW] + AW'(1);
        mem_wdata = rdata_q | free_mask[2*W-1:W];
        count_d   = (sum > (CW+1)'(NUM_BLK)) ? NUM_BLK : sum[CW-1:0];
        done_d    = 1'b1;
        bn_d      = '0;
        st_d      = bra_pkg::ST_OK;
        state_d   = S_IDLE;
      end
      S_C_RD: begin
        mem_re    = 1'b1;
        mem_raddr = blk_q[BW-1:AW];
        state_d   = S_C_WR;
      end
      S_C_WR: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (rdata_q[blk_q[AW-1:0]]) begin
          mem_we    = 1'b1;
          mem_waddr = blk_q[BW-1:AW];
          mem_wdata = rdata_q & ~({{(W-1){1'b0}}, 1'b1} << blk_q[AW-1:0]);
          count_d   = (count_q > CW'(1)) ? count_q - CW'(1) : '0;
          bn_d      = blk_q;
          st_d      = bra_pkg::ST_OK;
        end else begin
          bn_d = '0;
          st_d = bra_pkg::ST_NOT_FREE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_k_q   <= '0;
      count_q   <= '0;
      rotor_q   <= '0;
      retry_q   <= 1'b0;
      issue_k_q <= '0;
      pend_q    <= 1'b0;
      pend_k_q  <= '0;
      span_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_k_q   <= clr_k_d;
      count_q   <= count_d;
      rotor_q   <= rotor_d;
      retry_q   <= retry_d;
      issue_k_q <= issue_k_d;
      pend_q    <= pend_d;
      pend_k_q  <= pend_k_d;
      span_q    <= span_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q      <= blk_d;
    len_q      <= len_d;
    prev_raw_q <= prev_raw_d;
    prev_m_q   <= prev_m_d;
    wr_cur_q   <= wr_cur_d;
    wr_prev_q  <= wr_prev_d;
    wr_k_q     <= wr_k_d;
    s_q        <= s_d;
    bn_q       <= bn_d;
    st_q       <= st_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign block_number_o = bn_q;
  assign status_o       = st_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_start_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("item dropped");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NUM_BLK) else $error("free count above block total");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bra_pkg::ST_OK) |-> (block_number_o == '0))
    else $error("failed result carries a block number");

endmodule

>>> src/bra_run_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run finder
// Finds the lowest bit of the upper word at which a free run of the
// requested length ends, looking across the two-word window.
// ----------------------------------------------------------------------------
module bra_run_find (
  input  logic [2*bra_pkg::WORD_W-1:0] window_i,
  input  logic [bra_pkg::LEN_W-1:0]    len_i,
  output bra_pkg::find_t               find_o
);

  logic [bra_pkg::WORD_W-1:0] top_mask;
  logic [bra_pkg::WORD_W-1:0] hit;

  always_comb begin
    top_mask = ~({bra_pkg::WORD_W{1'b1}} >> len_i);
    for (int j = 0; j < bra_pkg::WORD_W; j++) begin
      hit[j] = &(window_i[j+bra_pkg::WORD_W -: bra_pkg::WORD_W] | ~top_mask);
    end
  end

  always_comb begin
    find_o.hit = |hit;
    find_o.pos = '0;
    for (int j = bra_pkg::WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        find_o.pos = bra_pkg::POS_W'(j);
      end
    end
  end

endmodule
